// ===== sv/vcrf_pkg.sv =====
// Shared types and constants for the voxel crop and row background fill block.
// Holds the item structs, register indexes and controller/datapath interfaces.
// No dependencies.
`default_nettype none

package vcrf_pkg;

  localparam int VOX_W      = 8;
  localparam int ORG_W      = 12;
  localparam int WX_W       = 7;
  localparam int WYZ_W      = 11;
  localparam int OUTX_W     = 6;
  localparam int CNT_W      = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_ENABLE = 3'd6;

  typedef struct packed {
    logic [VOX_W-1:0] voxel;
    logic             row_end;
    logic             plane_end;
    logic             image_end;
  } in_item_t;

  typedef struct packed {
    logic [VOX_W-1:0]  voxel_out;
    logic [OUTX_W-1:0] out_x;
    logic              last_in_row;
    logic              last_in_window;
    logic [CNT_W-1:0]  zeros_seen;
    logic [CNT_W-1:0]  ones_seen;
    logic [CNT_W-1:0]  others_seen;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take the input item this cycle
    logic issue;   // start a row buffer read
    logic load;    // load the output register from the row buffer data
  } vcrf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;      // the offered item completes a window row
    logic last;      // the position being loaded is the last of the row
    logic out_free;  // the output register can take a new item
  } vcrf_stat_t;

endpackage

`default_nettype wire

// ===== sv/vcrf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
`default_nettype none

module vcrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/vcrf_ctrl.sv =====
// Controller state machine: takes input items and sequences the row readout.
// Depends on vcrf_pkg for the command and status structs.
`default_nettype none

module vcrf_ctrl import vcrf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire vcrf_stat_t st,
  output vcrf_cmd_t       cmd
);

  typedef enum logic [1:0] {
    IDLE,
    PRIME,
    LOAD
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && st.emit) begin
          state_next = PRIME;
        end
      end
      PRIME: begin
        cmd.issue  = 1'b1;
        state_next = LOAD;
      end
      LOAD: begin
        if (st.out_free) begin
          cmd.load  = 1'b1;
          cmd.issue = !st.last;
          if (st.last) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The first read is always followed by the load state.
  a_prime_then_load: assert property (@(posedge clk) disable iff (rst)
    state == PRIME |=> state == LOAD)
    else $error("readout did not move from prime to load");

  // A blocked output keeps the readout parked on the same position.
  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (state == LOAD && !st.out_free) |=> state == LOAD)
    else $error("readout left load while the output was blocked");

endmodule

`default_nettype wire

// ===== sv/vcrf_datapath.sv =====
// Datapath: configuration registers, source position, crop test, row buffer,
// fill logic, saturating counts and the output register.
// Depends on vcrf_pkg and instantiates vcrf_ram.
`default_nettype none

module vcrf_datapath import vcrf_pkg::*; #(
  parameter int MAX_ROW     = 64,
  parameter int MAX_SRC_DIM = 4096,
  parameter int MAX_WIN_YZ  = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_item,
  input  wire vcrf_cmd_t             cmd,
  output vcrf_stat_t                 st
);

  localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
  localparam int SW = (MAX_SRC_DIM > 1) ? $clog2(MAX_SRC_DIM) : 1;
  localparam int XW = ((SW > ORG_W) ? SW : ORG_W) + 1;
  localparam logic [SW-1:0] SRC_MAX = SW'(MAX_SRC_DIM - 1);

  // Configuration registers.
  logic [ORG_W-1:0] origin_x, origin_y, origin_z;
  logic [WX_W-1:0]  window_x;
  logic [WYZ_W-1:0] window_y, window_z;
  logic             fill_enable;

  // Source position and per-row collection state.
  logic [SW-1:0]   src_col, src_row, src_plane;
  logic [WX_W-1:0] collected, first_nz, last_nz;
  logic            any_nz, row_sent;

  // Snapshot of the row being read out.
  logic [WX_W-1:0] e_collected, e_first, e_last, e_wx;
  logic            e_any, e_last_row, e_clear;

  logic [AW-1:0]    p;
  logic [CNT_W-1:0] zero_total, one_total, other_total;

  logic [WX_W-1:0] wx;
  logic [XW-1:0]   wy, wz, dx, dy, dz;
  logic            xin, yin, zin, eol, row_active, do_write, at_edge, nz, last_row;
  logic [WX_W-1:0] pos;
  logic [WX_W-1:0] collected_upd, first_upd, last_upd;
  logic            any_upd;

  logic [VOX_W-1:0] ram_q, base_val, val;
  logic [AW-1:0]    raddr;
  logic [WX_W-1:0]  p_ext;
  logic             filled;
  logic [CNT_W-1:0] zero_next, one_next, other_next;

  // Clamped window sizes.
  always_comb begin
    if (window_x == '0) begin
      wx = WX_W'(1);
    end else if (window_x > WX_W'(MAX_ROW)) begin
      wx = WX_W'(MAX_ROW);
    end else begin
      wx = window_x;
    end
    if (window_y == '0) begin
      wy = XW'(1);
    end else if (XW'(window_y) > XW'(MAX_WIN_YZ)) begin
      wy = XW'(MAX_WIN_YZ);
    end else begin
      wy = XW'(window_y);
    end
    if (window_z == '0) begin
      wz = XW'(1);
    end else if (XW'(window_z) > XW'(MAX_WIN_YZ)) begin
      wz = XW'(MAX_WIN_YZ);
    end else begin
      wz = XW'(window_z);
    end
  end

  // Crop test on the offered item.
  always_comb begin
    dx  = XW'(src_col) - XW'(origin_x);
    dy  = XW'(src_row) - XW'(origin_y);
    dz  = XW'(src_plane) - XW'(origin_z);
    xin = (XW'(src_col) >= XW'(origin_x)) && (dx < XW'(wx));
    yin = (XW'(src_row) >= XW'(origin_y)) && (dy < wy);
    zin = (XW'(src_plane) >= XW'(origin_z)) && (dz < wz);
    pos = dx[WX_W-1:0];
    eol = in_item.row_end || in_item.plane_end || in_item.image_end;
    nz  = (in_item.voxel != '0);
    row_active = yin && zin && !row_sent;
    do_write   = row_active && xin && (pos >= collected);
    at_edge    = xin && (pos == wx - WX_W'(1));
    last_row   = (dy == wy - XW'(1)) && (dz == wz - XW'(1));

    collected_upd = do_write ? pos + WX_W'(1) : collected;
    first_upd     = (do_write && nz && !any_nz) ? pos : first_nz;
    last_upd      = (do_write && nz) ? pos : last_nz;
    any_upd       = any_nz || (do_write && nz);
  end

  // Readout: the RAM data in hand belongs to position p.
  always_comb begin
    p_ext    = WX_W'(p);
    raddr    = cmd.load ? p + AW'(1) : p;
    base_val = (p_ext < e_collected) ? ram_q : '0;
    filled   = fill_enable && (!e_any || (p_ext < e_first) || (p_ext > e_last));
    val      = filled ? VOX_W'(1) : base_val;
    zero_next  = zero_total;
    one_next   = one_total;
    other_next = other_total;
    if (val == '0) begin
      zero_next = (zero_total == CNT_MAX) ? zero_total : zero_total + CNT_W'(1);
    end else if (val == VOX_W'(1)) begin
      one_next = (one_total == CNT_MAX) ? one_total : one_total + CNT_W'(1);
    end else begin
      other_next = (other_total == CNT_MAX) ? other_total : other_total + CNT_W'(1);
    end
  end

  assign st.emit     = row_active && (at_edge || eol);
  assign st.last     = (p_ext == e_wx - WX_W'(1));
  assign st.out_free = !out_valid || out_ready;

  vcrf_ram #(
    .WIDTH (VOX_W),
    .DEPTH (MAX_ROW)
  ) u_row_ram (
    .clk   (clk),
    .we    (cmd.accept && do_write),
    .waddr (pos[AW-1:0]),
    .wdata (in_item.voxel),
    .re    (cmd.issue),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      origin_z    <= '0;
      window_x    <= WX_W'(64);
      window_y    <= WYZ_W'(1024);
      window_z    <= WYZ_W'(1024);
      fill_enable <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORIGIN_X:    origin_x    <= cfg_data[ORG_W-1:0];
        REG_ORIGIN_Y:    origin_y    <= cfg_data[ORG_W-1:0];
        REG_ORIGIN_Z:    origin_z    <= cfg_data[ORG_W-1:0];
        REG_WINDOW_X:    window_x    <= cfg_data[WX_W-1:0];
        REG_WINDOW_Y:    window_y    <= cfg_data[WYZ_W-1:0];
        REG_WINDOW_Z:    window_z    <= cfg_data[WYZ_W-1:0];
        REG_FILL_ENABLE: fill_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Source position and row collection.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_col   <= '0;
      src_row   <= '0;
      src_plane <= '0;
      collected <= '0;
      first_nz  <= '0;
      last_nz   <= '0;
      any_nz    <= 1'b0;
      row_sent  <= 1'b0;
    end else if (cmd.accept) begin
      if (eol) begin
        collected <= '0;
        first_nz  <= '0;
        last_nz   <= '0;
        any_nz    <= 1'b0;
        row_sent  <= 1'b0;
        src_col   <= '0;
        if (in_item.image_end) begin
          src_row   <= '0;
          src_plane <= '0;
        end else if (in_item.plane_end) begin
          src_row   <= '0;
          src_plane <= (src_plane < SRC_MAX) ? src_plane + SW'(1) : src_plane;
        end else begin
          src_row <= (src_row < SRC_MAX) ? src_row + SW'(1) : src_row;
        end
      end else begin
        collected <= collected_upd;
        first_nz  <= first_upd;
        last_nz   <= last_upd;
        any_nz    <= any_upd;
        row_sent  <= row_sent || st.emit;
        src_col   <= (src_col < SRC_MAX) ? src_col + SW'(1) : src_col;
      end
    end
  end

  // Row snapshot and readout position.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      e_collected <= collected_upd;
      e_first     <= first_upd;
      e_last      <= last_upd;
      e_any       <= any_upd;
      e_wx        <= wx;
      e_last_row  <= last_row;
      e_clear     <= in_item.image_end;
      p           <= '0;
    end else if (cmd.load) begin
      p <= p + AW'(1);
    end
  end

  // Running counts; an image end clears them, after its own row is out if it completes one.
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_total  <= '0;
      one_total   <= '0;
      other_total <= '0;
    end else if (cmd.load) begin
      if (st.last && e_clear) begin
        zero_total  <= '0;
        one_total   <= '0;
        other_total <= '0;
      end else begin
        zero_total  <= zero_next;
        one_total   <= one_next;
        other_total <= other_next;
      end
    end else if (cmd.accept && in_item.image_end && !st.emit) begin
      zero_total  <= '0;
      one_total   <= '0;
      other_total <= '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_item.voxel_out      <= val;
      out_item.out_x          <= OUTX_W'(p);
      out_item.last_in_row    <= st.last;
      out_item.last_in_window <= st.last && e_last_row;
      out_item.zeros_seen     <= zero_next;
      out_item.ones_seen      <= one_next;
      out_item.others_seen    <= other_next;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded item not presented");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output item dropped before it was taken");

  a_window_end_is_row_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.last_in_window) |-> out_item.last_in_row)
    else $error("window end flagged off a row end");

  a_no_accept_in_readout: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.accept)
    else $error("input taken while a row is being read out");

endmodule

`default_nettype wire

// ===== sv/voxel_crop_row_background_fill_top.sv =====
// Top level of the voxel crop and row background fill block.
// Depends on vcrf_pkg; instantiates vcrf_ctrl and vcrf_datapath.
`default_nettype none

//  channel | signals                              | item
//  --------+--------------------------------------+------------------------------
//  input   | in_valid, in_ready, in_item          | one source voxel with marks
//  output  | out_valid, out_ready, out_item       | one window voxel with counts
//  config  | cfg_write, cfg_index, cfg_data       | one register write
//
// An input item that completes no window row leaves the block ready for the next
// one. An item that completes a row is taken, then the row buffer is primed with
// one read, and the row leaves at one item per cycle while the output is not
// stalled.
// Reset is synchronous and active high; the row buffer is not cleared, since
// only positions written in the current row are read.
// A stalled output holds its item and the readout waits; in_ready stays low
// until the last item of the row has been loaded into the output register.

module voxel_crop_row_background_fill_top import vcrf_pkg::*; #(
  parameter int MAX_ROW     = 64,
  parameter int MAX_SRC_DIM = 4096,
  parameter int MAX_WIN_YZ  = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_item
);

  vcrf_cmd_t  cmd;
  vcrf_stat_t st;

  // The controller only sequences; all state of the stream lives in the
  // datapath.
  vcrf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  vcrf_datapath #(
    .MAX_ROW     (MAX_ROW),
    .MAX_SRC_DIM (MAX_SRC_DIM),
    .MAX_WIN_YZ  (MAX_WIN_YZ)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

`default_nettype wire

// ===== tb/vcrf_crop_checker.sv =====
// Scoreboard for the voxel crop and row background fill block: predicts every
// window row from the accepted input items and checks the output items in order.
// Depends on vcrf_pkg only.
module vcrf_crop_checker import vcrf_pkg::*; #(
  parameter int MAX_ROW     = 64,
  parameter int MAX_SRC_DIM = 4096,
  parameter int MAX_WIN_YZ  = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  output int                    pending,
  output int                    mismatches,
  output int                    voxels_checked
);

  localparam int COUNT_LIMIT = 2**CNT_W - 1;

  logic [ORG_W-1:0] org_x, org_y, org_z;
  logic [WX_W-1:0]  win_x;
  logic [WYZ_W-1:0] win_y, win_z;
  logic             fill_on;

  logic [VOX_W-1:0] row_buf [MAX_ROW];
  int col, row, plane, collected, first_nz, last_nz;
  bit any_nz, row_done;
  int zero_total, one_total, other_total;

  out_item_t expected_voxels [$];

  function automatic int clamp_size(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic int step_pos(int v);
    return (v < MAX_SRC_DIM - 1) ? v + 1 : v;
  endfunction

  function automatic int count_up(int v);
    return (v < COUNT_LIMIT) ? v + 1 : v;
  endfunction

  // Collects one source voxel and queues the window row it completes, if any.
  task automatic crop_and_fill(input in_item_t it);
    int ox, oy, oz, wx, wy, wz, pos, p, val;
    bit eol, in_yz, at_right, last_row;
    out_item_t o;
    ox = int'(org_x);
    oy = int'(org_y);
    oz = int'(org_z);
    wx = clamp_size(int'(win_x), MAX_ROW);
    wy = clamp_size(int'(win_y), MAX_WIN_YZ);
    wz = clamp_size(int'(win_z), MAX_WIN_YZ);
    eol = it.row_end || it.plane_end || it.image_end;
    in_yz = row >= oy && row - oy < wy && plane >= oz && plane - oz < wz;
    if (in_yz && !row_done) begin
      at_right = 1'b0;
      if (col >= ox && col - ox < wx) begin
        pos = col - ox;
        // A position already collected is never overwritten.
        if (pos >= collected) begin
          row_buf[pos] = it.voxel;
          collected = pos + 1;
          if (it.voxel != '0) begin
            if (!any_nz) first_nz = pos;
            any_nz = 1'b1;
            last_nz = pos;
          end
        end
        at_right = (pos == wx - 1);
      end
      if (at_right || eol) begin
        last_row = (row - oy == wy - 1) && (plane - oz == wz - 1);
        for (p = 0; p < wx; p++) begin
          val = (p < collected) ? int'(row_buf[p]) : 0;
          if (fill_on && (!any_nz || p < first_nz || p > last_nz)) val = 1;
          if (val == 0) zero_total = count_up(zero_total);
          else if (val == 1) one_total = count_up(one_total);
          else other_total = count_up(other_total);
          o.voxel_out      = val[VOX_W-1:0];
          o.out_x          = p[OUTX_W-1:0];
          o.last_in_row    = (p == wx - 1);
          o.last_in_window = (p == wx - 1) && last_row;
          o.zeros_seen     = zero_total[CNT_W-1:0];
          o.ones_seen      = one_total[CNT_W-1:0];
          o.others_seen    = other_total[CNT_W-1:0];
          expected_voxels.push_back(o);
        end
        row_done = 1'b1;
      end
    end
    if (eol) begin
      collected = 0;
      first_nz = 0;
      last_nz = 0;
      any_nz = 1'b0;
      row_done = 1'b0;
      col = 0;
      if (it.image_end) begin
        row = 0;
        plane = 0;
        zero_total = 0;
        one_total = 0;
        other_total = 0;
      end else if (it.plane_end) begin
        row = 0;
        plane = step_pos(plane);
      end else begin
        row = step_pos(row);
      end
    end else begin
      col = step_pos(col);
    end
  endtask

  task automatic check_voxel(input out_item_t got);
    out_item_t want;
    if (expected_voxels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: output item with nothing expected: value %0d x %0d",
                 got.voxel_out, got.out_x);
    end else begin
      want = expected_voxels.pop_front();
      if (got.voxel_out !== want.voxel_out || got.out_x !== want.out_x ||
          got.last_in_row !== want.last_in_row ||
          got.last_in_window !== want.last_in_window ||
          got.zeros_seen !== want.zeros_seen || got.ones_seen !== want.ones_seen ||
          got.others_seen !== want.others_seen) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: output item %0d differs", voxels_checked);
          $display("  expected value %0d x %0d row/window end %b counts %0d/%0d/%0d",
                   want.voxel_out, want.out_x, {want.last_in_row, want.last_in_window},
                   want.zeros_seen, want.ones_seen, want.others_seen);
          $display("  actual   value %0d x %0d row/window end %b counts %0d/%0d/%0d",
                   got.voxel_out, got.out_x, {got.last_in_row, got.last_in_window},
                   got.zeros_seen, got.ones_seen, got.others_seen);
        end
      end
      voxels_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      org_x = '0;
      org_y = '0;
      org_z = '0;
      win_x = 7'd64;
      win_y = 11'd1024;
      win_z = 11'd1024;
      fill_on = 1'b1;
      col = 0;
      row = 0;
      plane = 0;
      collected = 0;
      first_nz = 0;
      last_nz = 0;
      any_nz = 1'b0;
      row_done = 1'b0;
      zero_total = 0;
      one_total = 0;
      other_total = 0;
      expected_voxels.delete();
    end else begin
      if (out_valid && out_ready) check_voxel(out_item);
      if (cfg_write) begin
        case (cfg_index)
          REG_ORIGIN_X:    org_x = cfg_data[ORG_W-1:0];
          REG_ORIGIN_Y:    org_y = cfg_data[ORG_W-1:0];
          REG_ORIGIN_Z:    org_z = cfg_data[ORG_W-1:0];
          REG_WINDOW_X:    win_x = cfg_data[WX_W-1:0];
          REG_WINDOW_Y:    win_y = cfg_data[WYZ_W-1:0];
          REG_WINDOW_Z:    win_z = cfg_data[WYZ_W-1:0];
          REG_FILL_ENABLE: fill_on = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) crop_and_fill(in_item);
    end
    pending = expected_voxels.size();
  end

endmodule

// ===== tb/voxel_crop_row_background_fill_top_tb.sv =====
// Testbench top for voxel_crop_row_background_fill_top: drives crop windows and
// voxel streams, lets vcrf_crop_checker score the output, and gives the verdict.
// Depends on vcrf_pkg, the block and vcrf_crop_checker.
module voxel_crop_row_background_fill_top_tb;
  import vcrf_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RANDOM_ITEMS = 200;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 1_500_000;
  // No register lives at this index; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;

  int pending, mismatches, voxels_checked;

  // Sender bookkeeping. holds_served belongs to the receiver process alone.
  int burst_left, items_sent, random_items, settings_applied;
  int hold_requests, holds_served;

  voxel_crop_row_background_fill_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  vcrf_crop_checker crop_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .pending       (pending),
    .mismatches    (mismatches),
    .voxels_checked(voxels_checked)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Voxel values lean toward 0 and 1 so that zero runs at the row edges, the
  // fill and all three running counts are exercised; the rest spans every bit.
  function automatic logic [VOX_W-1:0] pick_voxel();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4, 5:       return 8'd1;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one input item and returns at the clock edge that accepts it.
  // The sender works in bursts; between bursts valid drops for a random gap,
  // and sometimes the gap is zero so that long unbroken stretches occur too.
  // Inputs only change at the falling edge.
  task automatic offer_voxel(input logic [VOX_W-1:0] v, input bit re, pe, ie);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_item.voxel = v;
    in_item.row_end = re;
    in_item.plane_end = pe;
    in_item.image_end = ie;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Brings the block to rest: no input offered, every predicted output item
  // received, then a few more cycles for items that produce no output.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Registers are only rewritten once the block is idle.
  task automatic apply_window(input int ox, oy, oz, wx, wy, wz, fill);
    settle();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_WINDOW_X, wx);
    write_reg(REG_WINDOW_Y, wy);
    write_reg(REG_WINDOW_Z, wz);
    write_reg(REG_FILL_ENABLE, fill);
    settings_applied++;
  endtask

  // Sends one well-formed source image of sd planes of sh rows of sw voxels,
  // with some rows cut short and a few items carrying broken end marks.
  // A plane or image mark may come with or without the lower marks, since
  // each of them ends the row on its own. With stall_out set, the receiver is
  // asked for a long hold right after the first item, while the image streams.
  task automatic send_image(input int sw, sh, sd, input bit stall_out);
    int d, h, w, len;
    bit re, pe, ie;
    for (d = 0; d < sd; d++) begin
      for (h = 0; h < sh; h++) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, sw) : sw;
        for (w = 0; w < len; w++) begin
          re = (w == len - 1);
          pe = re && (h == sh - 1);
          ie = pe && (d == sd - 1);
          if (pe) re = 1'($urandom_range(0, 1));
          if (ie) pe = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 24) == 0) {re, pe, ie} = 3'($urandom_range(0, 7));
          offer_voxel(pick_voxel(), re, pe, ie);
          random_items++;
          if (stall_out && d == 0 && h == 0 && w == 0) hold_requests++;
        end
      end
    end
  endtask

  // The receiver runs stretches of its own stall pattern: always ready,
  // mostly ready, a coin toss, or a fixed three-of-five rhythm. On request it
  // holds ready low for a long count so the block backs up into its input.
  initial begin : receiver
    int mode, stretch, tick;
    out_ready = 1'b0;
    holds_served = 0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      stretch = $urandom_range(16, 160);
      repeat (stretch) begin
        @(negedge clk);
        tick++;
        if (holds_served < hold_requests) begin
          out_ready = 1'b0;
          repeat (LONG_HOLD) @(negedge clk);
          holds_served++;
        end else begin
          case (mode)
            0:       out_ready = 1'b1;
            1:       out_ready = ($urandom_range(0, 3) != 0);
            2:       out_ready = ($urandom_range(0, 1) != 0);
            default: out_ready = ((tick % 5) < 3);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int phase, ox, oy, oz, wx, wy, wz, wxe, sw, sh, sd, n, i, fill;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_ORIGIN_X;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    burst_left = 0;
    items_sent = 0;
    random_items = 0;
    settings_applied = 0;
    hold_requests = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. Window of 4 columns from column 1, rows 1..2, planes 0..1,
    // fill on. The write to the unused index must change nothing.
    apply_window(1, 1, 0, 4, 2, 2, 1);
    write_reg(REG_UNUSED, 4095);
    // A row above the window is dropped.
    offer_voxel(8'd255, 1'b1, 1'b0, 1'b0);
    // A long row: emitted when column 4 reaches the right edge; the leading
    // zero turns to 1, the inner zero stays, and the tail after the edge is
    // ignored.
    offer_voxel(8'd7, 1'b0, 1'b0, 1'b0);
    offer_voxel(8'd0, 1'b0, 1'b0, 1'b0);
    offer_voxel(8'd255, 1'b0, 1'b0, 1'b0);
    offer_voxel(8'd0, 1'b0, 1'b0, 1'b0);
    offer_voxel(8'd128, 1'b0, 1'b0, 1'b0);
    offer_voxel(8'd9, 1'b1, 1'b0, 1'b0);
    // A short row ended by a plane mark alone: missing positions read as 0,
    // so the whole row fills to ones.
    offer_voxel(8'd3, 1'b0, 1'b0, 1'b0);
    offer_voxel(8'd0, 1'b0, 1'b1, 1'b0);
    // Second plane: a row outside the window, then a row with no voxel inside
    // the window in x, which is still emitted at its end.
    offer_voxel(8'd5, 1'b1, 1'b0, 1'b0);
    offer_voxel(8'd1, 1'b1, 1'b0, 1'b0);
    // Last window row of the last window plane, cut short by the image mark:
    // its last output item closes the window, and the counts restart.
    offer_voxel(8'd0, 1'b0, 1'b0, 1'b0);
    offer_voxel(8'd0, 1'b0, 1'b0, 1'b0);
    offer_voxel(8'd0, 1'b0, 1'b0, 1'b0);
    offer_voxel(8'd200, 1'b0, 1'b0, 1'b1);
    // Fill off, and one item carrying all three marks at once.
    apply_window(0, 0, 0, 3, 2, 1, 0);
    offer_voxel(8'd0, 1'b0, 1'b0, 1'b0);
    offer_voxel(8'd1, 1'b1, 1'b1, 1'b1);

    // Random part: a new window per phase, then one or two images shaped to
    // cover it. Sizes sometimes sit at zero or beyond the limits to hit the
    // clamps. Phase 0 uses a fixed mid-size window and, like phase 3, a long
    // output hold while the input keeps coming.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 0) begin
        ox = 0;
        oy = 0;
        oz = 0;
        wx = 8;
        wy = 3;
        wz = 2;
        fill = 1;
      end else begin
        ox = $urandom_range(0, 3);
        oy = $urandom_range(0, 2);
        oz = $urandom_range(0, 1);
        case ($urandom_range(0, 9))
          0:       wx = 0;
          1:       wx = 64;
          2:       wx = $urandom_range(65, 127);
          default: wx = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 7))
          0:       wy = 0;
          1:       wy = $urandom_range(1025, 2047);
          2:       wy = 1024;
          default: wy = $urandom_range(1, 3);
        endcase
        case ($urandom_range(0, 7))
          0:       wz = 0;
          1:       wz = $urandom_range(1025, 2047);
          2:       wz = 1024;
          default: wz = $urandom_range(1, 3);
        endcase
        fill = $urandom_range(0, 1);
      end
      wxe = (wx < 1) ? 1 : ((wx > 64) ? 64 : wx);
      sw = ox + wxe + $urandom_range(0, 3) - 1;
      if (sw < 1) sw = 1;
      sh = oy + $urandom_range(1, 3);
      sd = oz + $urandom_range(1, 2);
      // Wide windows take long rows; keep those images to a single row.
      if (wxe > 16) begin
        oy = 0;
        oz = 0;
        sh = 1;
        sd = 1;
      end
      apply_window(ox, oy, oz, wx, wy, wz, fill);
      n = $urandom_range(1, 2);
      for (i = 0; i < n; i++) send_image(sw, sh, sd, (phase == 0 || phase == 3) && i == 0);
      phase++;
    end

    settle();
    $display("Run covered %0d input items (%0d in random images) under %0d window settings,",
             items_sent, random_items, settings_applied);
    $display("with %0d output items checked and %0d long output holds.",
             voxels_checked, holds_served);
    if (mismatches == 0 && pending == 0) begin
      $display("** voxel_crop_row_background_fill_top: PASSED **");
    end else begin
      $display("** voxel_crop_row_background_fill_top: FAILED **");
    end
    $finish;
  end

  // Hard limit well above the slowest correct run.
  initial begin : watchdog
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Timeout: %0d output items still expected.", pending);
    $display("** voxel_crop_row_background_fill_top: FAILED **");
    $finish;
  end

endmodule
